### src/lnedge_pkg.sv
// Shared constants and word types for the lane edge tracker.
package lnedge_pkg;

  localparam int COLS    = 64;
  localparam int ROWS    = 60;
  localparam int EDGE_W  = 7;
  localparam int IDX_W   = 6;
  localparam int SUM_W   = 12;
  localparam int OFS_W   = 8;
  localparam int ZEBRA_W = 7;
  localparam int MARGIN_W = 4;
  localparam int CFG_W   = 7;

  localparam int THIRD      = ROWS / 3;
  localparam int NEAR_COUNT = ROWS - 2 * THIRD;

  localparam logic [ZEBRA_W-1:0]  ZEBRA_RESET  = ZEBRA_W'(30);
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(5);

  localparam logic KIND_ROW     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [0:0] {
    CFG_ZEBRA_MIN_WIDTH = 1'b0,
    CFG_SEARCH_MARGIN   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [COLS-1:0] row_pixels;
    logic            frame_start;
  } in_word_t;

  typedef struct packed {
    logic                    kind;
    logic [EDGE_W-1:0]       left_edge;
    logic [EDGE_W-1:0]       right_edge;
    logic signed [OFS_W-1:0] offset_far;
    logic signed [OFS_W-1:0] offset_mid;
    logic signed [OFS_W-1:0] offset_near;
    logic                    stop_request;
    logic                    camera_valid;
    logic                    last_of_run;
  } out_word_t;

endpackage

### src/lane_edge_tracker.sv
// Lane edge tracker: per-row edge search, frame flags and third averages.
//
//   channel   direction  handshake           word
//   in_       input      in_valid/in_stall   in_word_t  (one image row)
//   out_      output     out_valid/out_stall out_word_t (row result or summary)
//   cfg_      input      cfg_we              cfg_idx selects, cfg_wdata carries
//
// One row per cycle while the queue has room and no summary waits: a row is held in
// the input register, and its result is written to a four-word result queue and shows
// at out_ from there. The last row of a frame also queues a summary; the queue takes
// one word a cycle, so the row after it waits in the input register for the summary.
// Reset is synchronous; it clears the queue, the frame state and reloads the
// registers. A stalled output only holds the queue; rows keep coming until full.
module lane_edge_tracker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lnedge_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lnedge_pkg::out_word_t out_data,
  input  logic                  cfg_we,
  input  lnedge_pkg::cfg_idx_t  cfg_idx,
  input  logic [lnedge_pkg::CFG_W-1:0] cfg_wdata
);
  import lnedge_pkg::*;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;
  localparam int START_W    = EDGE_W + 1;
  localparam int DIV_SH     = SUM_W + $clog2(ROWS);
  localparam int RCP_W      = DIV_SH + 1;
  localparam int PROD_W     = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_THIRD = RCP_W'(((2 ** DIV_SH) + THIRD - 1) / THIRD);
  localparam logic [RCP_W-1:0] RCP_NEAR  =
    RCP_W'(((2 ** DIV_SH) + NEAR_COUNT - 1) / NEAR_COUNT);
  localparam logic [EDGE_W-1:0] CENTRE   = EDGE_W'(COLS / 2);
  localparam logic [IDX_W-1:0]  FAR_FROM = IDX_W'(ROWS - THIRD);
  localparam logic [IDX_W-1:0]  MID_FROM = IDX_W'(ROWS - 2 * THIRD);
  localparam logic [IDX_W-1:0]  LAST_ROW = IDX_W'(ROWS - 1);

  // highest column at or below start whose pixel pair is black
  function automatic logic [EDGE_W-1:0] seek_left(logic [COLS-1:0] pairs,
                                                  logic [START_W-1:0] start);
    logic [EDGE_W-1:0] hit;
    hit = '0;
    for (int j = 1; j < COLS; j++) begin
      if (pairs[j] && (START_W'(j) <= start)) hit = EDGE_W'(j);
    end
    return hit;
  endfunction

  // lowest column at or above start whose pixel pair is black
  function automatic logic [EDGE_W-1:0] seek_right(logic [COLS-1:0] pairs,
                                                   logic [START_W-1:0] start);
    logic [EDGE_W-1:0] hit;
    hit = EDGE_W'(COLS);
    for (int j = COLS - 1; j >= 1; j--) begin
      if (pairs[j] && (START_W'(j) >= start)) hit = EDGE_W'(j);
    end
    return hit;
  endfunction

  // signed mean, truncated toward zero, by reciprocal multiply on the magnitude
  function automatic logic signed [OFS_W-1:0] mean_of(logic signed [SUM_W-1:0] s,
                                                      logic [RCP_W-1:0] rcp);
    logic [SUM_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [OFS_W-1:0]  q;
    mag  = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    prod = PROD_W'(mag) * PROD_W'(rcp);
    q    = OFS_W'(prod >> DIV_SH);
    return s[SUM_W-1] ? $signed(-q) : $signed(q);
  endfunction

  // configuration
  logic [ZEBRA_W-1:0]  zebra_min_r;
  logic [MARGIN_W-1:0] margin_r;

  // input register
  logic            s1_vld_r;
  logic            s1_vld_nxt;
  logic [COLS-1:0] s1_row_r;
  logic            s1_start_r;

  // frame state
  logic [EDGE_W-1:0]       prev_left_r,  prev_left_nxt;
  logic [EDGE_W-1:0]       prev_right_r, prev_right_nxt;
  logic [IDX_W-1:0]        row_idx_r,    row_idx_nxt;
  logic signed [SUM_W-1:0] sum_far_r,    sum_far_nxt;
  logic signed [SUM_W-1:0] sum_mid_r,    sum_mid_nxt;
  logic signed [SUM_W-1:0] sum_near_r,   sum_near_nxt;
  logic                    halted_r,     halted_nxt;
  logic                    stop_seen_r,  stop_seen_nxt;
  logic                    cam_ok_r,     cam_ok_nxt;
  logic                    sum_pend_r,   sum_pend_nxt;

  // result queue
  out_word_t          fifo_mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               can_push, push, pop;
  out_word_t          push_word;

  logic                    in_fire, s1_adv, s1_fire, row_live, first, last;
  logic [COLS-1:0]         pairs;
  logic [START_W-1:0]      left_start, right_start;
  logic [EDGE_W-1:0]       l_seek, r_seek, l_edge, r_edge, gap;
  logic                    zebra, centre;
  logic [IDX_W-1:0]        k;
  logic signed [SUM_W-1:0] term;
  out_word_t               row_word, sum_word;

  assign can_push  = (cnt_r != CNT_W'(FIFO_DEPTH));
  assign s1_adv    = can_push && !sum_pend_r;
  assign s1_fire   = s1_vld_r && s1_adv;
  assign in_stall  = s1_vld_r && !s1_adv;
  assign in_fire   = in_valid && !in_stall;
  assign s1_vld_nxt = in_fire || (s1_vld_r && !s1_adv);

  assign out_valid = (cnt_r != '0);
  assign out_data  = fifo_mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  // row search and frame bookkeeping
  always_comb begin
    first    = s1_start_r;
    row_live = s1_fire && (s1_start_r || (row_idx_r != '0));
    k        = first ? '0 : row_idx_r;
    last     = (k == LAST_ROW);

    pairs = ~s1_row_r & ~(s1_row_r << 1);

    left_start  = first ? START_W'(CENTRE) : START_W'(prev_left_r) + START_W'(margin_r);
    if (first) begin
      right_start = START_W'(CENTRE);
    end else if (prev_right_r > EDGE_W'(margin_r)) begin
      right_start = START_W'(prev_right_r - EDGE_W'(margin_r));
    end else begin
      right_start = START_W'(1);
    end

    l_seek = seek_left(pairs, left_start);
    r_seek = seek_right(pairs, right_start);

    // halted rows repeat the previous edges
    l_edge = (!first && halted_r) ? prev_left_r  : l_seek;
    r_edge = (!first && halted_r) ? prev_right_r : r_seek;

    gap    = r_edge - l_edge;
    zebra  = first && (gap < zebra_min_r);
    centre = first && !zebra && (l_edge == CENTRE) && (r_edge == CENTRE);

    term = $signed(SUM_W'(l_edge) + SUM_W'(r_edge) - SUM_W'(COLS));

    prev_left_nxt  = prev_left_r;
    prev_right_nxt = prev_right_r;
    row_idx_nxt    = row_idx_r;
    sum_far_nxt    = sum_far_r;
    sum_mid_nxt    = sum_mid_r;
    sum_near_nxt   = sum_near_r;
    halted_nxt     = halted_r;
    stop_seen_nxt  = stop_seen_r;
    cam_ok_nxt     = cam_ok_r;
    sum_pend_nxt   = sum_pend_r;

    if (row_live) begin
      // a frame start drops whatever frame was open
      if (first) begin
        sum_far_nxt  = '0;
        sum_mid_nxt  = '0;
        sum_near_nxt = '0;
      end
      halted_nxt    = (first ? 1'b0 : halted_r) || zebra || centre;
      stop_seen_nxt = (first ? 1'b0 : stop_seen_r) || zebra;
      cam_ok_nxt    = (first ? 1'b1 : cam_ok_r) && !centre;
      prev_left_nxt  = l_edge;
      prev_right_nxt = r_edge;
      if (k >= FAR_FROM) begin
        sum_far_nxt = sum_far_nxt + term;
      end else if (k >= MID_FROM) begin
        sum_mid_nxt = sum_mid_nxt + term;
      end else begin
        sum_near_nxt = sum_near_nxt + term;
      end
      row_idx_nxt  = last ? '0 : k + IDX_W'(1);
      sum_pend_nxt = last;
    end else if (sum_pend_r && can_push) begin
      sum_pend_nxt = 1'b0;
    end
  end

  always_comb begin
    row_word              = '0;
    row_word.kind         = KIND_ROW;
    row_word.left_edge    = l_edge;
    row_word.right_edge   = r_edge;
    row_word.stop_request = stop_seen_nxt;
    row_word.camera_valid = cam_ok_nxt;
    row_word.last_of_run  = !last;

    sum_word              = '0;
    sum_word.kind         = KIND_SUMMARY;
    sum_word.offset_far   = mean_of(sum_far_r, RCP_THIRD);
    sum_word.offset_mid   = mean_of(sum_mid_r, RCP_THIRD);
    sum_word.offset_near  = mean_of(sum_near_r, RCP_NEAR);
    sum_word.stop_request = stop_seen_r;
    sum_word.camera_valid = cam_ok_r;
    sum_word.last_of_run  = 1'b1;

    push      = row_live || (sum_pend_r && can_push);
    push_word = row_live ? row_word : sum_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zebra_min_r  <= ZEBRA_RESET;
      margin_r     <= MARGIN_RESET;
      s1_vld_r     <= 1'b0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      row_idx_r    <= '0;
      sum_far_r    <= '0;
      sum_mid_r    <= '0;
      sum_near_r   <= '0;
      halted_r     <= 1'b0;
      stop_seen_r  <= 1'b0;
      cam_ok_r     <= 1'b1;
      sum_pend_r   <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ZEBRA_MIN_WIDTH: zebra_min_r <= cfg_wdata[ZEBRA_W-1:0];
          CFG_SEARCH_MARGIN:   margin_r    <= cfg_wdata[MARGIN_W-1:0];
          default: ;
        endcase
      end
      s1_vld_r     <= s1_vld_nxt;
      prev_left_r  <= prev_left_nxt;
      prev_right_r <= prev_right_nxt;
      row_idx_r    <= row_idx_nxt;
      sum_far_r    <= sum_far_nxt;
      sum_mid_r    <= sum_mid_nxt;
      sum_near_r   <= sum_near_nxt;
      halted_r     <= halted_nxt;
      stop_seen_r  <= stop_seen_nxt;
      cam_ok_r     <= cam_ok_nxt;
      sum_pend_r   <= sum_pend_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_row_r   <= in_data.row_pixels;
      s1_start_r <= in_data.frame_start;
    end
    if (push) fifo_mem_r[wr_ptr_r] <= push_word;
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count beyond depth");

  a_pend_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
    sum_pend_r |-> (row_idx_r == '0))
    else $error("summary pending while a frame is still open");

  a_pend_blocks_row: assert property (@(posedge clk) disable iff (!rst_n)
    sum_pend_r |-> !s1_fire)
    else $error("row processed ahead of a pending summary");

  a_halt_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> (stop_seen_r || !cam_ok_r))
    else $error("tracking halted without stop or camera fault");

  a_stop_skips_centre: assert property (@(posedge clk) disable iff (!rst_n)
    stop_seen_r |-> cam_ok_r)
    else $error("centre check applied after a stop request");

  a_last_row_pends: assert property (@(posedge clk) disable iff (!rst_n)
    (row_live && last) |=> sum_pend_r)
    else $error("last row of a frame did not queue a summary");

endmodule

### tb/lane_edge_tracker_test.sv
// Self-checking testbench for the lane edge tracker: directed rows, then random frames.
`timescale 1ns / 1ps

module lane_edge_tracker_test;
  import lnedge_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_CAP     = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_ZEBRA_MIN_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  lane_edge_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // tracker state as the block should hold it
  int zebra_min = int'(ZEBRA_RESET);
  int margin = int'(MARGIN_RESET);
  int prev_l = 0;
  int prev_r = 0;
  int row_pos = 0;
  int sum_far = 0;
  int sum_mid = 0;
  int sum_near = 0;
  bit halted = 1'b0;
  bit stop_flag = 1'b0;
  bit cam_flag = 1'b1;

  out_word_t expected_words[$];
  int mismatches = 0;
  int rows_tracked = 0;
  int cycle_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[lane_edge_tracker] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
  endtask

  // check each result word against the oldest expectation
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with none expected", 64'(out_data), '0);
      end else begin
        want = expected_words.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch("kind", 64'(out_data.kind), 64'(want.kind));
        if (out_data.left_edge !== want.left_edge)
          report_mismatch("left_edge", 64'(out_data.left_edge), 64'(want.left_edge));
        if (out_data.right_edge !== want.right_edge)
          report_mismatch("right_edge", 64'(out_data.right_edge), 64'(want.right_edge));
        if (out_data.offset_far !== want.offset_far)
          report_mismatch("offset_far", 64'(out_data.offset_far), 64'(want.offset_far));
        if (out_data.offset_mid !== want.offset_mid)
          report_mismatch("offset_mid", 64'(out_data.offset_mid), 64'(want.offset_mid));
        if (out_data.offset_near !== want.offset_near)
          report_mismatch("offset_near", 64'(out_data.offset_near),
                          64'(want.offset_near));
        if (out_data.stop_request !== want.stop_request)
          report_mismatch("stop_request", 64'(out_data.stop_request),
                          64'(want.stop_request));
        if (out_data.camera_valid !== want.camera_valid)
          report_mismatch("camera_valid", 64'(out_data.camera_valid),
                          64'(want.camera_valid));
        if (out_data.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", 64'(out_data.last_of_run),
                          64'(want.last_of_run));
      end
    end
  end

  function automatic int seek_left_edge(logic [COLS-1:0] px, int start);
    if (start > COLS - 1) start = COLS - 1;
    for (int j = start; j >= 1; j--)
      if (!px[j] && !px[j-1]) return j;
    return 0;
  endfunction

  function automatic int seek_right_edge(logic [COLS-1:0] px, int start);
    if (start < 1) start = 1;
    for (int j = start; j < COLS; j++)
      if (!px[j] && !px[j-1]) return j;
    return COLS;
  endfunction

  // advance the tracker by one row, queue the words it owes, return their count
  function automatic int track_edges(in_word_t w);
    int k;
    int l;
    int r;
    out_word_t res;
    if (w.frame_start) begin
      row_pos = 0;
      sum_far = 0;
      sum_mid = 0;
      sum_near = 0;
      halted = 1'b0;
      stop_flag = 1'b0;
      cam_flag = 1'b1;
    end else if (row_pos == 0) begin
      return 0;  // no open frame: drop the row
    end
    k = row_pos;
    if (k == 0) begin
      l = seek_left_edge(w.row_pixels, COLS / 2);
      r = seek_right_edge(w.row_pixels, COLS / 2);
      if (r - l < zebra_min) begin
        stop_flag = 1'b1;
        halted = 1'b1;
      end else if (l == COLS / 2 && r == COLS / 2) begin
        cam_flag = 1'b0;
        halted = 1'b1;
      end
    end else if (halted) begin
      l = prev_l;
      r = prev_r;
    end else begin
      l = seek_left_edge(w.row_pixels, prev_l + margin);
      r = seek_right_edge(w.row_pixels, (prev_r > margin) ? prev_r - margin : 1);
    end
    prev_l = l;
    prev_r = r;
    if (k >= ROWS - THIRD) sum_far += l + r - COLS;
    else if (k >= ROWS - 2 * THIRD) sum_mid += l + r - COLS;
    else sum_near += l + r - COLS;

    res = '0;
    res.kind = KIND_ROW;
    res.left_edge = EDGE_W'(l);
    res.right_edge = EDGE_W'(r);
    res.stop_request = stop_flag;
    res.camera_valid = cam_flag;
    res.last_of_run = (k + 1 < ROWS);
    expected_words.push_back(res);
    if (k + 1 >= ROWS) begin
      res = '0;
      res.kind = KIND_SUMMARY;
      res.offset_far = OFS_W'(sum_far / THIRD);
      res.offset_mid = OFS_W'(sum_mid / THIRD);
      res.offset_near = OFS_W'(sum_near / NEAR_COUNT);
      res.stop_request = stop_flag;
      res.camera_valid = cam_flag;
      res.last_of_run = 1'b1;
      expected_words.push_back(res);
      row_pos = 0;
      return 2;
    end
    row_pos = k + 1;
    return 1;
  endfunction

  task automatic send_row(logic [COLS-1:0] px, logic fs);
    int gap;
    in_word_t w;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.row_pixels = px;
    w.frame_start = fs;
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (track_edges(w) > 0) rows_tracked++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // registers change only with the block idle
  task automatic set_config(int zebra, int mrg);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_ZEBRA_MIN_WIDTH;
    cfg_wdata <= CFG_W'(zebra);
    @(posedge clk);
    cfg_idx <= CFG_SEARCH_MARGIN;
    cfg_wdata <= CFG_W'(mrg);
    @(posedge clk);
    cfg_we <= 1'b0;
    zebra_min = zebra;
    margin = mrg;
  endtask

  // white row with black pairs ending at columns l and r
  function automatic logic [COLS-1:0] pair_row(int l, int r);
    logic [COLS-1:0] px;
    px = '1;
    if (l >= 1 && l < COLS) begin
      px[l] = 1'b0;
      px[l-1] = 1'b0;
    end
    if (r >= 1 && r < COLS) begin
      px[r] = 1'b0;
      px[r-1] = 1'b0;
    end
    return px;
  endfunction

  function automatic logic [COLS-1:0] noise_row();
    return {$urandom, $urandom};
  endfunction

  task automatic test_edges_and_margins();
    send_row(noise_row(), 1'b0);  // no frame open yet
    send_row('1, 1'b1);
    send_row('1, 1'b0);
    send_row('0, 1'b0);
    send_row(pair_row(1, 63), 1'b0);
  endtask

  task automatic test_stop_and_halt();
    send_row('0, 1'b1);  // both edges at centre, gap zero: stop
    send_row(noise_row(), 1'b0);
    send_row(noise_row(), 1'b0);
  endtask

  task automatic test_config_extremes();
    set_config(0, 15);
    send_row('0, 1'b1);  // centre edges with no stop threshold: camera invalid
    send_row(noise_row(), 1'b0);
    send_row(pair_row(30, 34), 1'b1);
    send_row('0, 1'b0);
    send_row('0, 1'b0);
    send_row('0, 1'b0);
    set_config(64, 0);
    send_row('1, 1'b1);
    send_row('1, 1'b0);
    send_row('0, 1'b0);
    send_row(pair_row(31, 33), 1'b1);
    set_config(30, 5);
  endtask

  task automatic send_frame(int n);
    int l;
    int r;
    l = $urandom_range(2, 31);
    r = $urandom_range(33, 63);
    if ($urandom_range(4) == 0) begin
      l = $urandom_range(20, 31);
      r = l + $urandom_range(1, 25);
    end
    send_row(pair_row(l, r), 1'b1);
    for (int i = 1; i < n; i++) begin
      l = l + $urandom_range(4) - 2;
      r = r + $urandom_range(4) - 2;
      if (l < 0) l = 0;
      if (l > COLS - 1) l = COLS - 1;
      if (r < 1) r = 1;
      if (r > COLS) r = COLS;
      if ($urandom_range(9) == 0) begin
        send_row(noise_row(), 1'b0);
      end else if ($urandom_range(3) == 0) begin
        // sprinkle black specks that may form extra pairs
        send_row(pair_row(l, r) & noise_row() | noise_row(), 1'b0);
      end else begin
        send_row(pair_row(l, r), 1'b0);
      end
    end
  endtask

  task automatic test_random_frames(int idle, int stall, int zebra, int mrg, int target);
    int pick;
    int stop_at;
    set_config(zebra, mrg);
    idle_pct = idle;
    stall_pct = stall;
    stop_at = rows_tracked + target;
    while (rows_tracked < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame(ROWS);
        if ($urandom_range(3) == 0) wait_drained();
      end else if (pick < 80) begin
        send_frame($urandom_range(1, ROWS - 1));
      end else begin
        repeat ($urandom_range(1, 6)) send_row(noise_row(), $urandom_range(9) == 0);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edges_and_margins();
    test_stop_and_halt();
    test_config_extremes();

    test_random_frames(0, 0, 30, 5, 180);
    test_random_frames(69, 0, 45, 0, 180);
    test_random_frames(0, 69, 12, 15, 180);
    test_random_frames(6, 6, $urandom_range(0, 64), $urandom_range(0, 15), 180);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[lane_edge_tracker] OK");
    end else begin
      $display("[lane_edge_tracker] ERROR");
    end
    $finish;
  end

endmodule
